// ===== sv/life_generation_stencil_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the life generation stencil checker.
// ----------------------------------------------------------------------------
`ifndef LIFE_GENERATION_STENCIL_TOP_ASSERT_SVH
`define LIFE_GENERATION_STENCIL_TOP_ASSERT_SVH

// Clocked assertion, switched off while reset is held.
`define LGS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define LGS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/lgs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared types, codes and rule functions of the life generation stencil.
// ----------------------------------------------------------------------------
package lgs_pkg;

  localparam int CFG_W         = 9;
  localparam int CFG_IDX_W     = 1;
  localparam int MAX_WIDTH_DEF = 256;
  localparam int HEIGHT_MAX    = 256;
  localparam int WIDTH_LIMIT   = 511;

  typedef logic [1:0]           cell_t;
  typedef logic [CFG_IDX_W-1:0] reg_idx_t;
  typedef logic [CFG_W-1:0]     dim_t;

  localparam cell_t CELL_DEAD  = 2'd0;
  localparam cell_t CELL_LIVE  = 2'd1;
  localparam cell_t CELL_WALL  = 2'd2;
  localparam cell_t CELL_OTHER = 2'd3;

  localparam logic KIND_CELL  = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  localparam reg_idx_t REG_GRID_WIDTH  = 1'd0;
  localparam reg_idx_t REG_GRID_HEIGHT = 1'd1;

  // Neighbor counts of the B3/S23 rule.
  localparam logic [3:0] CNT_SURVIVE = 4'd2;
  localparam logic [3:0] CNT_BIRTH   = 4'd3;

  // One column of the 3x3 window.
  typedef struct packed {
    cell_t top;
    cell_t mid;
    cell_t bot;
  } col_t;

  // Which cells of a column count as neighbors.
  typedef struct packed {
    logic top_ok;
    logic mid_ok;
    logic bot_ok;
  } mask_t;

  // One line store entry.
  typedef struct packed {
    cell_t upper;
    cell_t middle;
  } line_t;

  // Per-item control from the stream counters to the window stage.
  typedef struct packed {
    logic due;       // item produces a result
    logic top_ok;    // row above the result lies in the grid
    logic bot_ok;    // row below the result lies in the grid
    logic left_ok;   // column left of the result lies in the grid
    logic right_ok;  // column right of the result lies in the grid
    logic row_end;
    logic grid_end;
  } ctl_t;

  function automatic logic [1:0] live_count(col_t c, mask_t m);
    logic a;
    logic b;
    logic d;
    a = (c.top == CELL_LIVE) && m.top_ok;
    b = (c.mid == CELL_LIVE) && m.mid_ok;
    d = (c.bot == CELL_LIVE) && m.bot_ok;
    return {1'b0, a} + {1'b0, b} + {1'b0, d};
  endfunction

  function automatic cell_t evolve_cell(cell_t centre, logic [3:0] cnt);
    cell_t res;
    case (centre)
      CELL_WALL: res = CELL_WALL;
      CELL_LIVE: res = (cnt == CNT_SURVIVE || cnt == CNT_BIRTH) ? CELL_LIVE : CELL_DEAD;
      CELL_DEAD: res = (cnt == CNT_BIRTH) ? CELL_LIVE : CELL_DEAD;
      default:   res = CELL_DEAD;
    endcase
    return res;
  endfunction

endpackage

// ===== sv/lgs_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgs_if
// Valid/ready channels of the life generation stencil: cells in, results
// out, register writes.
// ----------------------------------------------------------------------------
interface lgs_in_if;
  import lgs_pkg::*;
  logic  valid;
  logic  ready;
  logic  kind;
  cell_t cell_code;
  modport source (output valid, output kind, output cell_code, input ready);
  modport sink   (input valid, input kind, input cell_code, output ready);
endinterface

interface lgs_out_if;
  import lgs_pkg::*;
  logic  valid;
  logic  ready;
  cell_t next_cell;
  logic  row_end;
  logic  grid_end;
  modport source (output valid, output next_cell, output row_end, output grid_end,
                  input ready);
  modport sink   (input valid, input next_cell, input row_end, input grid_end,
                  output ready);
endinterface

interface lgs_cfg_if;
  import lgs_pkg::*;
  logic     valid;
  logic     ready;
  reg_idx_t index;
  dim_t     data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/lgs_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lgs_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];  // old data on same-address collision
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/lgs_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgs_cell
// One window column: holds three cells, takes the column of its right
// neighbor on each shift and reports its masked live count.
// ----------------------------------------------------------------------------
module lgs_cell (
  input  logic          clk,
  input  logic          shift_en,
  input  lgs_pkg::col_t col_in,
  input  lgs_pkg::mask_t mask,
  output lgs_pkg::col_t col_out,
  output logic [1:0]    live_cnt
);
  import lgs_pkg::*;

  col_t col_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      col_r <= col_in;
    end
  end

  assign col_out  = col_r;
  assign live_cnt = live_count(col_r, mask);

endmodule

// ===== sv/lgs_rule.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgs_rule
// Sums the neighbor counts of the window and applies B3/S23 with walls.
// ----------------------------------------------------------------------------
module lgs_rule (
  input  logic           [1:0] left_cnt,
  input  logic           [1:0] ctr_cnt,
  input  lgs_pkg::col_t        right_col,
  input  lgs_pkg::mask_t       right_mask,
  input  lgs_pkg::cell_t       centre,
  output lgs_pkg::cell_t       next_cell
);
  import lgs_pkg::*;

  logic [1:0] right_cnt;
  logic [3:0] total;

  assign right_cnt = live_count(right_col, right_mask);
  assign total     = {2'b00, left_cnt} + {2'b00, ctr_cnt} + {2'b00, right_cnt};
  assign next_cell = evolve_cell(centre, total);

endmodule

// ===== sv/life_generation_stencil_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_generation_stencil_top
// One generation of the B3/S23 life rule over a walled grid streamed in
// raster order, with a line store RAM and a two-column window chain.
// ----------------------------------------------------------------------------
//
//   channel  | dir | payload                          | item
//   ---------+-----+----------------------------------+------------------------
//   in_ch    | in  | kind, cell_code                  | one grid cell or flush
//   out_ch   | out | next_cell, row_end, grid_end     | one next-generation cell
//   cfg_ch   | in  | index, data                      | one register write
//
// Flow: one item per cycle unless a held result stalls stage 1; the item that
//   causes a result passes through stage 1, then the output register.
// The line store RAM has one read and one write port; the registered read
//   turnaround is covered by a one-entry bypass of the last write.
// Reset: counters, valid flags and grid size only; line and window contents are
//   never cleared since every cell outside the current grid is masked out.
// Stalls: a held result blocks only items that also produce a result; cfg_ch is
//   always ready; the user must write it only while the stream is idle (unchecked).
// ----------------------------------------------------------------------------
module life_generation_stencil_top #(
  parameter int MAX_WIDTH = lgs_pkg::MAX_WIDTH_DEF
) (
  input logic     clk,
  input logic     rst_n,
  lgs_in_if.sink  in_ch,
  lgs_out_if.source out_ch,
  lgs_cfg_if.sink cfg_ch
);
  import lgs_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  // Largest usable width: bounded by MAX_WIDTH and by the register width.
  localparam dim_t WIDTH_CAP  = CFG_W'((MAX_WIDTH < WIDTH_LIMIT) ? MAX_WIDTH : WIDTH_LIMIT);
  localparam dim_t WIDTH_RST  = CFG_W'((MAX_WIDTH < HEIGHT_MAX) ? MAX_WIDTH : HEIGHT_MAX);
  localparam dim_t HEIGHT_CAP = CFG_W'(HEIGHT_MAX);

  // --------------------------------------------------------------------------
  // Configuration: registers hold the effective (clamped) dimensions.
  // --------------------------------------------------------------------------
  dim_t width_r,  width_nxt;
  dim_t height_r, height_nxt;
  logic cfg_wr;

  assign cfg_ch.ready = 1'b1;
  assign cfg_wr       = cfg_ch.valid;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_wr) begin
      unique case (cfg_ch.index)
        REG_GRID_WIDTH: begin
          if (cfg_ch.data == '0) begin
            width_nxt = dim_t'(1);
          end else if (cfg_ch.data > WIDTH_CAP) begin
            width_nxt = WIDTH_CAP;
          end else begin
            width_nxt = cfg_ch.data;
          end
        end
        REG_GRID_HEIGHT: begin
          if (cfg_ch.data == '0) begin
            height_nxt = dim_t'(1);
          end else if (cfg_ch.data > HEIGHT_CAP) begin
            height_nxt = HEIGHT_CAP;
          end else begin
            height_nxt = cfg_ch.data;
          end
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: stream position, input cell, result flags, line store read.
  // Row r of the stream writes row r; the result of row r-1 comes out
  // one row and one cell later. Rows h and h+1 are flush rows, and the
  // last cell of each row comes out at column 0 of the row after next.
  // --------------------------------------------------------------------------
  dim_t  col_r, col_nxt;
  dim_t  row_r, row_nxt;
  logic  in_take;
  logic  s1_go;
  logic  s1_valid_r, s1_valid_nxt;
  cell_t s0_v;
  ctl_t  s0_ctl;
  logic  first_col;

  assign in_ch.ready = !s1_valid_r || s1_go;
  assign in_take     = in_ch.valid && in_ch.ready;
  assign first_col   = (col_r == '0);

  always_comb begin
    if (in_ch.kind == KIND_FLUSH || row_r >= height_r) begin
      s0_v = CELL_DEAD;
    end else begin
      s0_v = in_ch.cell_code;
    end
    // first column: last cell of row r-2; otherwise cell (r-1, c-1)
    s0_ctl.due      = first_col ? (row_r >= dim_t'(2))
                                : (row_r >= dim_t'(1) && row_r <= height_r);
    s0_ctl.top_ok   = first_col ? (row_r >= dim_t'(3)) : (row_r >= dim_t'(2));
    s0_ctl.bot_ok   = first_col ? (row_r <= height_r) : (row_r < height_r);
    s0_ctl.left_ok  = first_col ? (width_r >= dim_t'(2)) : (col_r >= dim_t'(2));
    s0_ctl.right_ok = !first_col;
    s0_ctl.row_end  = first_col;
    s0_ctl.grid_end = first_col && (row_r == height_r + dim_t'(1));
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_wr) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (in_take) begin
      if (row_r >= height_r + dim_t'(1)) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (col_r + dim_t'(1) >= width_r) begin
        col_nxt = '0;
        row_nxt = row_r + dim_t'(1);
      end else begin
        col_nxt = col_r + dim_t'(1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: line store update, window shift, rule.
  // --------------------------------------------------------------------------
  logic [AW-1:0] s1_addr_r;
  cell_t         s1_v_r;
  ctl_t          s1_ctl_r;

  logic          out_valid_r, out_valid_nxt;
  cell_t         out_cell_r;
  logic          out_row_end_r;
  logic          out_grid_end_r;

  logic          bypass_valid_r;
  logic [AW-1:0] bypass_addr_r;
  line_t         bypass_data_r;

  line_t         ram_rd;
  line_t         line_rd;
  line_t         line_wr;
  col_t          new_col;
  col_t          ctr_col;
  col_t          left_col;
  mask_t         left_mask;
  mask_t         ctr_mask;
  mask_t         right_mask;
  logic [1:0]    left_cnt;
  logic [1:0]    ctr_cnt;
  cell_t         rule_cell;

  assign s1_go = s1_valid_r && (!s1_ctl_r.due || !out_valid_r || out_ch.ready);
  assign s1_valid_nxt = in_take || (s1_valid_r && !s1_go);

  lgs_ram #(
    .WIDTH ($bits(line_t)),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (s1_go),
    .wr_addr (s1_addr_r),
    .wr_data (line_wr),
    .rd_en   (in_take),
    .rd_addr (AW'(col_r)),
    .rd_data (ram_rd)
  );

  // The last write is the newest copy of its entry.
  assign line_rd = (bypass_valid_r && bypass_addr_r == s1_addr_r) ? bypass_data_r : ram_rd;

  // Row r-1 moves to the upper line, the incoming row to the middle line.
  assign line_wr.upper  = line_rd.middle;
  assign line_wr.middle = s1_v_r;

  assign new_col.top = line_rd.upper;
  assign new_col.mid = line_rd.middle;
  assign new_col.bot = s1_v_r;

  // Window chain: incoming column -> centre cell -> left cell.
  assign left_mask.top_ok  = s1_ctl_r.left_ok && s1_ctl_r.top_ok;
  assign left_mask.mid_ok  = s1_ctl_r.left_ok;
  assign left_mask.bot_ok  = s1_ctl_r.left_ok && s1_ctl_r.bot_ok;
  assign ctr_mask.top_ok   = s1_ctl_r.top_ok;
  assign ctr_mask.mid_ok   = 1'b0;  // the centre itself
  assign ctr_mask.bot_ok   = s1_ctl_r.bot_ok;
  assign right_mask.top_ok = s1_ctl_r.right_ok && s1_ctl_r.top_ok;
  assign right_mask.mid_ok = s1_ctl_r.right_ok;
  assign right_mask.bot_ok = s1_ctl_r.right_ok && s1_ctl_r.bot_ok;

  lgs_cell u_ctr_cell (
    .clk      (clk),
    .shift_en (s1_go),
    .col_in   (new_col),
    .mask     (ctr_mask),
    .col_out  (ctr_col),
    .live_cnt (ctr_cnt)
  );

  lgs_cell u_left_cell (
    .clk      (clk),
    .shift_en (s1_go),
    .col_in   (ctr_col),
    .mask     (left_mask),
    .col_out  (left_col),
    .live_cnt (left_cnt)
  );

  lgs_rule u_rule (
    .left_cnt   (left_cnt),
    .ctr_cnt    (ctr_cnt),
    .right_col  (new_col),
    .right_mask (right_mask),
    .centre     (ctr_col.mid),
    .next_cell  (rule_cell)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_go && s1_ctl_r.due) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r        <= WIDTH_RST;
      height_r       <= HEIGHT_CAP;
      col_r          <= '0;
      row_r          <= '0;
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      bypass_valid_r <= 1'b0;
    end else begin
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_go) begin
        bypass_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_addr_r <= AW'(col_r);
      s1_v_r    <= s0_v;
      s1_ctl_r  <= s0_ctl;
    end
    if (s1_go) begin
      bypass_addr_r <= s1_addr_r;
      bypass_data_r <= line_wr;
    end
    if (s1_go && s1_ctl_r.due) begin
      out_cell_r     <= rule_cell;
      out_row_end_r  <= s1_ctl_r.row_end;
      out_grid_end_r <= s1_ctl_r.grid_end;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.next_cell = out_cell_r;
  assign out_ch.row_end   = out_row_end_r;
  assign out_ch.grid_end  = out_grid_end_r;

endmodule

// ===== sv/lgs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgs_checker
// Port-level checks of the life generation stencil, bound to the top level.
// ----------------------------------------------------------------------------
`include "life_generation_stencil_top_assert.svh"

module lgs_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input lgs_pkg::cell_t       out_next_cell,
  input logic                 out_row_end,
  input logic                 out_grid_end
);
  import lgs_pkg::*;

  // A stalled result stays offered.
  `LGS_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result dropped while stalled")

  // A stalled result keeps its payload.
  `LGS_ASSERT(a_out_stable, clk, rst_n, out_valid && !out_ready |=> $stable(out_next_cell) && $stable(out_row_end) && $stable(out_grid_end), "result changed while stalled")

  // A fresh result must come from an item taken before it.
  `LGS_ASSERT(a_out_cause, clk, rst_n, $rose(out_valid) |-> $past(in_valid && in_ready, 2), "result without a causing item")

  // Reset empties the output register.
  `LGS_ASSERT_ALWAYS(a_out_reset, clk, !rst_n |=> !out_valid, "result offered after reset")

endmodule

bind life_generation_stencil_top lgs_checker u_lgs_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_next_cell (out_ch.next_cell),
  .out_row_end   (out_ch.row_end),
  .out_grid_end  (out_ch.grid_end)
);
